// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ITP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ITP_ASSERT_NEVER(label, expr, msg) \
    `ITP_ASSERT(label, !(expr), msg)

`endif

// ===== sv/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// character classes, stack codes and helpers for the postfix converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itp_pkg;

    localparam int CharW = 8;

    // stack entry codes
    typedef logic [2:0] code_t;
    localparam code_t CODE_LPAR = 3'd0;
    localparam code_t CODE_ADD  = 3'd1;
    localparam code_t CODE_SUB  = 3'd2;
    localparam code_t CODE_MUL  = 3'd3;
    localparam code_t CODE_DIV  = 3'd4;

    // input character classes
    typedef logic [2:0] cls_t;
    localparam cls_t CLS_NONE = 3'd0;
    localparam cls_t CLS_OPND = 3'd1;
    localparam cls_t CLS_LPAR = 3'd2;
    localparam cls_t CLS_OP   = 3'd3;
    localparam cls_t CLS_RPAR = 3'd4;
    localparam cls_t CLS_EQ   = 3'd5;

    typedef logic [CharW-1:0] char_t;
    localparam char_t CH_LPAR = 8'h28;
    localparam char_t CH_RPAR = 8'h29;
    localparam char_t CH_MUL  = 8'h2A;
    localparam char_t CH_ADD  = 8'h2B;
    localparam char_t CH_SUB  = 8'h2D;
    localparam char_t CH_DIV  = 8'h2F;
    localparam char_t CH_EQ   = 8'h3D;
    localparam char_t CH_0    = 8'h30;
    localparam char_t CH_9    = 8'h39;
    localparam char_t CH_UA   = 8'h41;
    localparam char_t CH_UZ   = 8'h5A;
    localparam char_t CH_LA   = 8'h61;
    localparam char_t CH_LZ   = 8'h7A;

    function automatic cls_t char_class(input char_t c);
        cls_t r;
        r = CLS_NONE;
        if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
            (c >= CH_0 && c <= CH_9))
            r = CLS_OPND;
        else if (c == CH_LPAR)
            r = CLS_LPAR;
        else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV)
            r = CLS_OP;
        else if (c == CH_RPAR)
            r = CLS_RPAR;
        else if (c == CH_EQ)
            r = CLS_EQ;
        return r;
    endfunction

    function automatic code_t char_to_code(input char_t c);
        code_t r;
        case (c)
            CH_ADD:  r = CODE_ADD;
            CH_SUB:  r = CODE_SUB;
            CH_MUL:  r = CODE_MUL;
            default: r = CODE_DIV;
        endcase
        return r;
    endfunction

    function automatic char_t code_to_char(input code_t code);
        char_t r;
        case (code)
            CODE_LPAR: r = CH_LPAR;
            CODE_ADD:  r = CH_ADD;
            CODE_SUB:  r = CH_SUB;
            CODE_MUL:  r = CH_MUL;
            CODE_DIV:  r = CH_DIV;
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] prec(input code_t code);
        logic [1:0] r;
        case (code)
            CODE_ADD, CODE_SUB: r = 2'd1;
            CODE_MUL, CODE_DIV: r = 2'd2;
            default:            r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/itp_ram.sv =====
// ----------------------------------------------------------------------------
// itp_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// streaming shunting-yard converter from infix to postfix characters
// ----------------------------------------------------------------------------
// One ASCII character enters per input item; postfix characters leave as
// output items, m_tlast marking the final item caused by an input and
// m_tuser[0] carrying the sticky overflow flag as it stood before that
// input. The operator stack lives in a small ram with a registered read,
// so the top of stack is fetched ahead and examined in a check state:
// operands, ignored characters and '(' are handled on acceptance; an
// operator, ')' or '=' enters the check state, which pops one operator
// per step until the scan stops. Output backpressure can stall the scan.
// A single output register holds each result; a new input item is taken
// only while that register is empty or being read in the same cycle.
// No clearing pass is needed after reset: only entries below the stack
// count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    // input items
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    // output items
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // last
    output logic [0:0] m_tuser    // [0] overflow
);

    import itp_pkg::*;

    localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CntW  = $clog2(STACK_DEPTH + 1);

    // sequencer states
    localparam logic S_IDLE  = 1'b0;
    localparam logic S_CHECK = 1'b1;

    logic            state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            err_reg, err_next;
    cls_t            cls_reg, cls_next;
    code_t           op_reg, op_next;

    // held pop, sent once we know whether it is the final one
    char_t           pend_char_reg, pend_char_next;
    logic            pend_valid_reg, pend_valid_next;

    // output register
    logic            out_valid_reg;
    char_t           out_char_reg;
    logic            out_last_reg;
    logic            out_ovf_reg;

    logic            send;
    char_t           send_char;
    logic            send_last;

    // stack ram ports
    logic            wr_en;
    logic [AddrW-1:0] wr_addr;
    code_t           wr_data;
    logic [AddrW-1:0] rd_addr;
    code_t           rd_data;
    logic [CntW-1:0] rd_cnt;

    logic            s_accept;
    logic            out_free;
    logic            full;
    logic            empty;
    cls_t            in_cls;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign full     = (count_reg == CntW'(STACK_DEPTH));
    assign empty    = (count_reg == '0);
    assign in_cls   = char_class(s_tdata);

    // writes always land at the current count
    assign wr_addr = count_reg[AddrW-1:0];

    // always fetch the entry that will be top of stack next cycle
    assign rd_cnt  = count_next - CntW'(1);
    assign rd_addr = rd_cnt[AddrW-1:0];

    itp_ram #(
        .WIDTH ($bits(code_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        logic stop;
        stop            = 1'b0;
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        cls_next        = cls_reg;
        op_next         = op_reg;
        pend_char_next  = pend_char_reg;
        pend_valid_next = pend_valid_reg;
        send            = 1'b0;
        send_char       = pend_char_reg;
        send_last       = 1'b0;
        wr_en           = 1'b0;
        wr_data         = op_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_cls)
                        CLS_OPND:
                        begin
                            send      = 1'b1;
                            send_char = s_tdata;
                            send_last = 1'b1;
                        end
                        CLS_LPAR:
                        begin
                            if (full)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = CODE_LPAR;
                                count_next = count_reg + CntW'(1);
                            end
                        end
                        CLS_OP, CLS_RPAR, CLS_EQ:
                        begin
                            cls_next   = in_cls;
                            op_next    = char_to_code(s_tdata);
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            // ignored character
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                // rd_data is the top of stack whenever the stack is not empty
                case (cls_reg)
                    CLS_OP:   stop = empty || (rd_data == CODE_LPAR) ||
                                     (prec(rd_data) < prec(op_reg));
                    CLS_RPAR: stop = empty || (rd_data == CODE_LPAR);
                    default:  stop = empty;
                endcase

                if (!stop)
                begin
                    // pop one operator, sending the one held before it
                    if (!pend_valid_reg || out_free)
                    begin
                        send            = pend_valid_reg;
                        count_next      = count_reg - CntW'(1);
                        pend_char_next  = code_to_char(rd_data);
                        pend_valid_next = 1'b1;
                    end
                end
                else if (cls_reg == CLS_EQ)
                begin
                    if (out_free)
                    begin
                        send = 1'b1;
                        if (pend_valid_reg)
                        begin
                            pend_valid_next = 1'b0;
                        end
                        else
                        begin
                            // terminator closes the expression
                            send_char  = CH_EQ;
                            send_last  = 1'b1;
                            err_next   = 1'b0;
                            count_next = '0;
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (!pend_valid_reg || out_free)
                begin
                    send            = pend_valid_reg;
                    send_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                    if (cls_reg == CLS_OP)
                    begin
                        if (full)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CntW'(1);
                        end
                    end
                    else if (!empty)
                    begin
                        // matching '(' is dropped
                        count_next = count_reg - CntW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            err_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            if (send)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cls_reg       <= cls_next;
        op_reg        <= op_next;
        pend_char_reg <= pend_char_next;
        if (send)
        begin
            out_char_reg <= send_char;
            out_last_reg <= send_last;
            out_ovf_reg  <= err_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_char_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_ovf_reg;

    // checks
    `ITP_ASSERT(a_count_range, count_reg <= CntW'(STACK_DEPTH), "stack count beyond depth")
    `ITP_ASSERT(a_pend_idle, (state_reg == S_IDLE) |-> !pend_valid_reg, "held pop left in idle")
    `ITP_ASSERT_NEVER(a_push_full, wr_en && full, "stack write on full stack")
    `ITP_ASSERT(a_op_check, (s_accept && (in_cls == CLS_OP)) |=> (state_reg == S_CHECK), "operator did not start stack scan")

endmodule

// ===== verif/infix_to_postfix_converter_test.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_test
// self-checking stream testbench for the postfix converter
// ----------------------------------------------------------------------------
// Characters are queued by a stimulus process and sent by a clocked driver.
// The driver runs each accepted item through a local shunting-yard predictor,
// and the expected postfix items are queued. A clocked monitor compares each
// output item field by field with the oldest expected one. Stimulus is a
// short directed run, then mostly well-formed expressions with random
// content, some deep nesting that can fill the stack, broken sequences and
// noise characters, under three idle patterns on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_to_postfix_converter_test;

    import itp_pkg::*;

    localparam int StackDepth  = 32;
    localparam int HalfPeriod  = 6;
    localparam int DrainCycles = 40;
    localparam int PhaseQuota  = 85;

    typedef struct packed {
        char_t ch;
        logic  last;
        logic  ovf;
    } postfix_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    // stimulus and expected output
    char_t         pending_chars[$];
    postfix_item_t postfix_expected[$];
    int            stim_count = 0;
    int            error_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    // predictor state
    code_t op_pending[StackDepth];
    int    op_count = 0;
    logic  overflow_seen = 1'b0;

    infix_to_postfix_converter #(
        .STACK_DEPTH(StackDepth)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #HalfPeriod clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // ---------------- predictor ----------------

    function automatic bit is_operand(input char_t c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
    endfunction

    function automatic bit is_significant(input char_t c);
        return is_operand(c) || (c inside {CH_LPAR, CH_RPAR, CH_ADD, CH_SUB, CH_MUL, CH_DIV,
                                           CH_EQ});
    endfunction

    function automatic int op_rank(input code_t code);
        if (code == CODE_ADD || code == CODE_SUB)
            return 1;
        if (code == CODE_MUL || code == CODE_DIV)
            return 2;
        return 0;
    endfunction

    task automatic expect_char(input char_t c);
        postfix_item_t item;
        item.ch   = c;
        item.last = 1'b0;
        item.ovf  = overflow_seen;
        postfix_expected.push_back(item);
    endtask

    task automatic pop_to_output();
        char_t c;
        op_count--;
        case (op_pending[op_count])
            CODE_ADD: c = CH_ADD;
            CODE_SUB: c = CH_SUB;
            CODE_MUL: c = CH_MUL;
            CODE_DIV: c = CH_DIV;
            default:  c = CH_LPAR;
        endcase
        expect_char(c);
    endtask

    task automatic push_op(input code_t code);
        if (op_count >= StackDepth)
            overflow_seen = 1'b1;
        else
        begin
            op_pending[op_count] = code;
            op_count++;
        end
    endtask

    task automatic convert_char(input char_t c);
        int    first;
        code_t code;
        bit    matched;
        first = postfix_expected.size();
        if (is_operand(c))
            expect_char(c);
        else if (c == CH_LPAR)
            push_op(CODE_LPAR);
        else if (c inside {CH_ADD, CH_SUB, CH_MUL, CH_DIV})
        begin
            code = (c == CH_ADD) ? CODE_ADD : (c == CH_SUB) ? CODE_SUB :
                   (c == CH_MUL) ? CODE_MUL : CODE_DIV;
            while (op_count > 0 && op_pending[op_count-1] != CODE_LPAR &&
                   op_rank(op_pending[op_count-1]) >= op_rank(code))
                pop_to_output();
            push_op(code);
        end
        else if (c == CH_RPAR)
        begin
            matched = 1'b0;
            while (op_count > 0 && !matched)
            begin
                if (op_pending[op_count-1] == CODE_LPAR)
                begin
                    op_count--;
                    matched = 1'b1;
                end
                else
                    pop_to_output();
            end
        end
        else if (c == CH_EQ)
        begin
            while (op_count > 0)
                pop_to_output();
            expect_char(CH_EQ);
            overflow_seen = 1'b0;
            op_count = 0;
        end
        // mark the final item caused by this character
        if (postfix_expected.size() > first)
            postfix_expected[postfix_expected.size()-1].last = 1'b1;
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        logic holding;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            holding = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                convert_char(s_tdata);
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin
        postfix_item_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (postfix_expected.size() == 0)
                    report_mismatch($sformatf("unexpected item char=%02h", m_tdata));
                else
                begin
                    want = postfix_expected.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch($sformatf("char got %02h want %02h", m_tdata, want.ch));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last got %b want %b (char %02h)",
                                                  m_tlast, want.last, want.ch));
                    if (m_tuser[0] !== want.ovf)
                        report_mismatch($sformatf("overflow got %b want %b (char %02h)",
                                                  m_tuser[0], want.ovf, want.ch));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- stimulus ----------------

    task automatic add_char(input char_t c);
        pending_chars.push_back(c);
        if (is_significant(c))
            stim_count++;
    endtask

    task automatic add_string(input string s);
        foreach (s[i])
            add_char(char_t'(s[i]));
    endtask

    function automatic char_t rand_operand();
        case ($urandom_range(2))
            0:       return char_t'("A" + $urandom_range(25));
            1:       return char_t'("a" + $urandom_range(25));
            default: return char_t'("0" + $urandom_range(9));
        endcase
    endfunction

    function automatic char_t rand_operator();
        case ($urandom_range(3))
            0:       return CH_ADD;
            1:       return CH_SUB;
            2:       return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    task automatic gen_term(input int nest);
        if (nest < 4 && $urandom_range(3) == 0)
        begin
            add_char(CH_LPAR);
            gen_expr(nest + 1);
            add_char(CH_RPAR);
        end
        else
            add_char(rand_operand());
    endtask

    task automatic gen_expr(input int nest);
        int terms;
        terms = $urandom_range(3);
        gen_term(nest);
        repeat (terms)
        begin
            add_char(rand_operator());
            gen_term(nest);
        end
    endtask

    // nesting that runs the stack full at 16 or more levels, so pushes get dropped
    task automatic gen_deep();
        int levels;
        levels = $urandom_range(12, 20);
        repeat (levels)
        begin
            add_char(rand_operand());
            add_char(rand_operator());
            add_char(CH_LPAR);
        end
        add_char(rand_operand());
        add_char(CH_MUL);
        add_char(rand_operand());
        repeat ($urandom_range(levels))
        begin
            add_char(CH_RPAR);
            if ($urandom_range(1))
            begin
                add_char(rand_operator());
                add_char(rand_operand());
            end
        end
        add_char(CH_EQ);
    endtask

    task automatic gen_broken();
        repeat ($urandom_range(1, 10))
        begin
            case ($urandom_range(4))
                0:       add_char(CH_LPAR);
                1:       add_char(CH_RPAR);
                2:       add_char(rand_operator());
                default: add_char(rand_operand());
            endcase
        end
        if ($urandom_range(1))
            add_char(CH_EQ);
    endtask

    task automatic fill_phase(input int quota);
        int start_count;
        int pick;
        start_count = stim_count;
        gen_deep();
        while (stim_count - start_count < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                gen_expr(0);
                add_char(CH_EQ);
            end
            else if (pick < 82)
            begin
                repeat ($urandom_range(1, 4))
                    add_char(char_t'($urandom_range(255)));
            end
            else if (pick < 96)
                gen_broken();
            else
                gen_deep();
        end
    endtask

    // holds off the sender until every expected item has come back
    task automatic wait_drained();
        @(negedge clk);
        while (pending_chars.size() != 0 || s_tvalid || postfix_expected.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    initial
    begin
        send_idle_pct = 10;
        recv_idle_pct = 81;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: operand extremes, all operators, parens, unmatched ')',
        // ignored codes, bare terminator
        add_string("A+b*(0-9)/Z-a=");
        add_string("x*y)z=");
        add_char(8'h00);
        add_char(8'hFF);
        add_char(8'h80);
        add_char(CH_EQ);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct = 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_idle_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            fill_phase(PhaseQuota);
            wait_drained();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== infix_to_postfix_converter.f =====
+incdir+sv
sv/itp_pkg.sv
sv/itp_ram.sv
sv/infix_to_postfix_converter.sv
verif/infix_to_postfix_converter_test.sv
